// ===== rtl/core/chm_pkg.sv =====
package chm_pkg;

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_REMOVE = 2'd2,
        REQ_NONE   = 2'd3
    } req_type_t;

    localparam int unsigned KEY_W = 32;
    localparam int unsigned VAL_W = 32;

endpackage

// ===== rtl/core/chm_ram.sv =====
module chm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/chained_hash_map_unit.sv =====
// Channel   Dir  Fields (lowest bit up)
// s_axis    in   tdata: req_type[1:0], req_key[33:2], req_value[65:34], pad to 72
// m_axis    out  tdata: hit[0], old_value[32:1], status[33], pad to 40
//
// One request at a time. S_HEAD and S_HWAIT read the bucket head, S_CHECK and
// S_EWAIT walk the chain until a match or its end, then S_DECIDE and S_OUT set
// the result; each chain step waits on the registered entry memory read.
// An insert of a new key waits in the decide step until the background
// free-entry search, one entry a cycle, has an entry.
// After reset a clearing pass empties the bucket heads.
// The result sits in an output register; the next request is taken only in
// the cycle after that beat has been accepted.
module chained_hash_map_unit #(
    parameter int unsigned BUCKETS = 16,
    parameter int unsigned ENTRIES = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // req_type, req_key, req_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // hit, old_value, status
);

    localparam int unsigned EW = $clog2(ENTRIES + 1);
    localparam int unsigned EA = $clog2(ENTRIES > 1 ? ENTRIES : 2);
    localparam int unsigned BA = $clog2(BUCKETS > 1 ? BUCKETS : 2);
    localparam int unsigned BW = $clog2(BUCKETS + 1);
    localparam logic [EW-1:0] NIL = EW'(ENTRIES);
    localparam int unsigned RW = chm_pkg::KEY_W + chm_pkg::VAL_W + EW;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HEAD, S_HWAIT, S_CHECK, S_EWAIT, S_DECIDE, S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [BW-1:0] clr_reg, clr_next;
    logic [1:0] type_reg, type_next;
    logic [31:0] key_reg, key_next, val_reg, val_next;
    logic [EW-1:0] cur_reg, cur_next, pred_reg, pred_next;
    logic [EW:0] steps_reg, steps_next;
    logic [EW-1:0] head_reg, head_next;
    logic found_reg, found_next;
    logic [31:0] fdata_reg, fdata_next;
    logic [EW-1:0] flink_reg, flink_next;
    logic [ENTRIES-1:0] use_reg, use_next;
    logic ov_reg, ov_next, ohit_reg, ohit_next, ostat_reg, ostat_next;
    logic [31:0] oval_reg, oval_next;
    logic [EW-1:0] free_reg, free_next;
    logic [EA-1:0] scan_reg, scan_next;

    logic          h_we;
    logic [BA-1:0] h_wa, h_ra;
    logic [EW-1:0] h_wd, h_rd;
    logic          e_we;
    logic [EA-1:0] e_wa, e_ra;
    logic [RW-1:0] e_wd, e_rd;
    logic [BA-1:0] bkt;
    logic          valid_op;

    assign bkt = BA'(key_reg % BUCKETS);
    assign valid_op = (type_reg != chm_pkg::REQ_NONE);

    chm_ram #(.WIDTH(EW), .DEPTH(BUCKETS)) u_head (
        .clk(clk), .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd)
    );
    chm_ram #(.WIDTH(RW), .DEPTH(ENTRIES)) u_entry (
        .clk(clk), .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata = {6'd0, ostat_reg, oval_reg, ohit_reg};

    // Sequencer and read-modify-write of the chain
    always_comb
    begin
        state_next = state_reg;
        clr_next = clr_reg;
        type_next = type_reg;
        key_next = key_reg;
        val_next = val_reg;
        cur_next = cur_reg;
        pred_next = pred_reg;
        steps_next = steps_reg;
        head_next = head_reg;
        found_next = found_reg;
        fdata_next = fdata_reg;
        flink_next = flink_reg;
        use_next = use_reg;
        ov_next = ov_reg;
        ohit_next = ohit_reg;
        ostat_next = ostat_reg;
        oval_next = oval_reg;
        free_next = free_reg;
        scan_next = scan_reg;
        h_we = 1'b0;
        h_wa = bkt;
        h_wd = NIL;
        h_ra = bkt;
        e_we = 1'b0;
        e_wa = cur_reg[EA-1:0];
        e_wd = {key_reg, val_reg, head_reg};
        e_ra = cur_reg[EA-1:0];

        if (ov_reg && m_axis_tready)
        begin
            ov_next = 1'b0;
        end

        // Background search for the lowest free entry
        if (free_reg == NIL)
        begin
            if (!use_reg[scan_reg])
            begin
                free_next = EW'(scan_reg);
            end
            scan_next = (32'(scan_reg) == ENTRIES - 1) ? '0 : scan_reg + 1'b1;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                h_we = 1'b1;
                h_wa = clr_reg[BA-1:0];
                clr_next = clr_reg + 1'b1;
                if (32'(clr_reg) == BUCKETS - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    type_next = s_axis_tdata[1:0];
                    key_next = s_axis_tdata[33:2];
                    val_next = s_axis_tdata[65:34];
                    state_next = S_HEAD;
                end
            end
            S_HEAD:
            begin
                state_next = S_HWAIT;
            end
            S_HWAIT:
            begin
                head_next = h_rd;
                cur_next = h_rd;
                pred_next = NIL;
                steps_next = '0;
                found_next = 1'b0;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                e_ra = cur_reg[EA-1:0];
                if (cur_reg >= NIL || 32'(steps_reg) >= ENTRIES)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    state_next = S_EWAIT;
                end
            end
            S_EWAIT:
            begin
                if (e_rd[RW-1 -: 32] == key_reg)
                begin
                    found_next = 1'b1;
                    fdata_next = e_rd[EW +: 32];
                    flink_next = e_rd[EW-1:0];
                    state_next = S_DECIDE;
                end
                else
                begin
                    pred_next = cur_reg;
                    cur_next = e_rd[EW-1:0];
                    steps_next = steps_reg + 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_DECIDE:
            begin
                ohit_next = found_reg && valid_op;
                oval_next = (found_reg && valid_op) ? fdata_reg : '0;
                ostat_next = 1'b0;
                state_next = S_OUT;
                if (type_reg == chm_pkg::REQ_INSERT)
                begin
                    if (found_reg)
                    begin
                        e_we = 1'b1;
                        e_wa = cur_reg[EA-1:0];
                        e_wd = {key_reg, val_reg, flink_reg};
                    end
                    else if (free_reg != NIL)
                    begin
                        e_we = 1'b1;
                        e_wa = free_reg[EA-1:0];
                        e_wd = {key_reg, val_reg, head_reg};
                        h_we = 1'b1;
                        h_wd = free_reg;
                        use_next[free_reg[EA-1:0]] = 1'b1;
                        free_next = NIL;
                        scan_next = '0;
                    end
                    else if (&use_reg)
                    begin
                        ostat_next = 1'b1;
                    end
                    else
                    begin
                        // Hold until the search reports a free entry
                        state_next = S_DECIDE;
                    end
                end
                else if (type_reg == chm_pkg::REQ_REMOVE && found_reg)
                begin
                    if (pred_reg != NIL)
                    begin
                        // Read predecessor, then relink it in S_OUT
                        e_ra = pred_reg[EA-1:0];
                    end
                    else
                    begin
                        h_we = 1'b1;
                        h_wd = flink_reg;
                    end
                    use_next[cur_reg[EA-1:0]] = 1'b0;
                    // Entries below the scan position are all in use
                    if ((free_reg == NIL && cur_reg <= EW'(scan_reg)) ||
                        (free_reg != NIL && cur_reg < free_reg))
                    begin
                        free_next = cur_reg;
                    end
                end
            end
            S_OUT:
            begin
                if (type_reg == chm_pkg::REQ_REMOVE && found_reg && pred_reg != NIL)
                begin
                    e_we = 1'b1;
                    e_wa = pred_reg[EA-1:0];
                    e_wd = {e_rd[RW-1:EW], flink_reg};
                end
                ov_next = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Entry chosen by the scan may have been taken this cycle
        if (free_next != NIL && use_next[free_next[EA-1:0]] && free_next == free_reg)
        begin
            free_next = NIL;
        end
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            use_reg <= '0;
            ov_reg <= 1'b0;
            free_reg <= NIL;
            scan_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            use_reg <= use_next;
            ov_reg <= ov_next;
            free_reg <= free_next;
            scan_reg <= scan_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        type_reg <= type_next;
        key_reg <= key_next;
        val_reg <= val_next;
        cur_reg <= cur_next;
        pred_reg <= pred_next;
        steps_reg <= steps_next;
        head_reg <= head_next;
        found_reg <= found_next;
        fdata_reg <= fdata_next;
        flink_reg <= flink_next;
        ohit_reg <= ohit_next;
        ostat_reg <= ostat_next;
        oval_reg <= oval_next;
    end

endmodule

// ===== sim/testbench.sv =====
module testbench;

    localparam int NBKT = 16;
    localparam int NENT = 64;
    localparam int NIL  = NENT;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;   // req_type, req_key, req_value
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;   // hit, old_value, status

    typedef struct packed {
        logic        status;
        logic [31:0] old_value;
        logic        hit;
    } map_reply_t;

    // Shadow of the hash table
    int          head_of[NBKT];
    bit          busy_ent[NENT];
    logic [31:0] ent_key[NENT];
    logic [31:0] ent_val[NENT];
    int          ent_next[NENT];

    map_reply_t  pending_replies[$];
    int          err_count;
    bit          rx_idle_en;
    bit          tx_idle_en;
    bit          rx_hold;
    logic [31:0] live_keys[$];

    chained_hash_map_unit #(.BUCKETS(NBKT), .ENTRIES(NENT)) dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
        err_count++;
    endtask

    // Apply one request to the shadow table and return the reply it earns
    function automatic map_reply_t map_apply(chm_pkg::req_type_t op, logic [31:0] key,
                                             logic [31:0] val);
        map_reply_t r;
        int cur;
        int prev;
        int found;
        int steps;
        int b;
        int f;
        r = '0;
        if (op == chm_pkg::REQ_NONE)
            return r;
        b = key % NBKT;
        cur = head_of[b];
        prev = NIL;
        found = NIL;
        steps = 0;
        while (cur < NIL && steps < NENT)
        begin
            if (ent_key[cur] == key)
            begin
                found = cur;
                break;
            end
            prev = cur;
            cur = ent_next[cur];
            steps++;
        end
        if (found < NIL)
        begin
            r.hit = 1'b1;
            r.old_value = ent_val[found];
        end
        if (op == chm_pkg::REQ_INSERT)
        begin
            if (found < NIL)
                ent_val[found] = val;
            else
            begin
                f = NIL;
                for (int i = 0; i < NENT; i++)
                    if (!busy_ent[i] && f == NIL)
                        f = i;
                if (f < NIL)
                begin
                    busy_ent[f] = 1'b1;
                    ent_key[f] = key;
                    ent_val[f] = val;
                    ent_next[f] = head_of[b];
                    head_of[b] = f;
                end
                else
                    r.status = 1'b1;
            end
        end
        else if (op == chm_pkg::REQ_REMOVE && found < NIL)
        begin
            if (prev < NIL)
                ent_next[prev] = ent_next[found];
            else
                head_of[b] = ent_next[found];
            busy_ent[found] = 1'b0;
        end
        return r;
    endfunction

    // Offer one beat, wait for acceptance, then queue its expected reply
    task automatic send_req(chm_pkg::req_type_t op, logic [31:0] key, logic [31:0] val);
        if (tx_idle_en && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
        end
        s_axis_tdata  <= {6'd0, val, key, op};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_replies.push_back(map_apply(op, key, val));
        if (op == chm_pkg::REQ_INSERT)
            live_keys.push_back(key);
        @(negedge clk);
    endtask

    // Receiver back-pressure
    always @(negedge clk)
    begin
        if (rx_hold)
            m_axis_tready <= 1'b0;
        else if (rx_idle_en && $urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clk);
            m_axis_tready <= 1'b1;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Compare each reply beat with the oldest expectation
    always @(posedge clk)
    begin
        map_reply_t got;
        map_reply_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[33:0];
            if (pending_replies.size() == 0)
            begin
                $display("MISMATCH unexpected reply %h at %0t", got, $time);
                err_count++;
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got.hit != want.hit)
                    report_mismatch("hit", got.hit, want.hit);
                if (got.old_value != want.old_value)
                    report_mismatch("old_value", got.old_value, want.old_value);
                if (got.status != want.status)
                    report_mismatch("status", got.status, want.status);
            end
        end
    end

    function automatic logic [31:0] pick_key();
        int n;
        n = $urandom_range(0, 9);
        if (n < 5 && live_keys.size() > 0)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        if (n < 8)
            return {28'($urandom_range(0, 7)), 4'($urandom_range(0, 3))};
        return $urandom;
    endfunction

    // Field extremes, every operation, misses and the unused type
    task automatic test_directed();
        send_req(chm_pkg::REQ_LOOKUP, 32'h0, 32'h0);
        send_req(chm_pkg::REQ_REMOVE, 32'hFFFF_FFFF, 32'h0);
        send_req(chm_pkg::REQ_INSERT, 32'h0, 32'hFFFF_FFFF);
        send_req(chm_pkg::REQ_INSERT, 32'hFFFF_FFFF, 32'h0);
        send_req(chm_pkg::REQ_INSERT, 32'h10, 32'hA5A5_5A5A);
        send_req(chm_pkg::REQ_INSERT, 32'h20, 32'h5A5A_A5A5);
        send_req(chm_pkg::REQ_LOOKUP, 32'h0, 32'h1234);
        send_req(chm_pkg::REQ_LOOKUP, 32'h10, 32'h0);
        send_req(chm_pkg::REQ_INSERT, 32'h10, 32'h1111_1111);
        send_req(chm_pkg::REQ_REMOVE, 32'h10, 32'hFFFF_FFFF);
        send_req(chm_pkg::REQ_LOOKUP, 32'h20, 32'h0);
        send_req(chm_pkg::REQ_LOOKUP, 32'h10, 32'h0);
        send_req(chm_pkg::REQ_NONE, 32'h20, 32'hFFFF_FFFF);
        send_req(chm_pkg::REQ_REMOVE, 32'h0, 32'h0);
        send_req(chm_pkg::REQ_REMOVE, 32'h20, 32'h0);
        send_req(chm_pkg::REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
    endtask

    // Fill the pool past full, drop everything again
    task automatic test_pool_full();
        for (int i = 0; i < NENT + 6; i++)
            send_req(chm_pkg::REQ_INSERT, $urandom, $urandom);
        for (int i = 0; i < NENT + 4; i++)
            send_req(chm_pkg::REQ_REMOVE, live_keys[$urandom_range(0, live_keys.size() - 1)],
                     $urandom);
        for (int i = 0; i < NENT; i++)
            if (busy_ent[i])
                send_req(chm_pkg::REQ_REMOVE, ent_key[i], 32'h0);
    endtask

    // Stall the receiver for a long stretch while requests keep coming
    task automatic test_backpressure();
        fork
            begin
                rx_hold = 1'b1;
                repeat (300) @(negedge clk);
                rx_hold = 1'b0;
            end
            for (int i = 0; i < 20; i++)
                send_req(chm_pkg::req_type_t'($urandom_range(0, 2)), pick_key(), $urandom);
        join
    endtask

    task automatic test_random(int count);
        chm_pkg::req_type_t op;
        int n;
        for (int i = 0; i < count; i++)
        begin
            n = $urandom_range(0, 19);
            op = (n < 8) ? chm_pkg::REQ_INSERT : (n < 13) ? chm_pkg::REQ_LOOKUP :
                 (n < 19) ? chm_pkg::REQ_REMOVE : chm_pkg::REQ_NONE;
            send_req(op, pick_key(), $urandom);
        end
    endtask

    initial
    begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        rx_idle_en = 1'b1;
        tx_idle_en = 1'b1;
        rx_hold = 1'b0;
        err_count = 0;
        for (int i = 0; i < NBKT; i++)
            head_of[i] = NIL;
        for (int i = 0; i < NENT; i++)
        begin
            busy_ent[i] = 1'b0;
            ent_next[i] = 0;
        end
        rst_n = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_pool_full();
        test_backpressure();
        test_random(1200);
        rx_idle_en = 1'b0;
        tx_idle_en = 1'b0;
        test_random(400);
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
